/* rtl/core/lcfe_pkg.sv */
// ---------------------------------------------------------------------------
// lcfe_pkg
// Shared types, codes and the add-rule flag function of the lazy condition
// flag evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package lcfe_pkg;

   // Flag vector covers bits 0 through 8 of the status word.
   localparam int unsigned FLAG_W = 9;
   typedef logic [FLAG_W-1:0] flags_type;

   localparam flags_type FL_C = 9'h001;
   localparam flags_type FL_V = 9'h002;
   localparam flags_type FL_Z = 9'h004;
   localparam flags_type FL_N = 9'h008;
   localparam flags_type FL_X = 9'h010;
   localparam flags_type FL_R = 9'h100;

   // Operation classes.
   typedef logic [2:0] func_type;
   localparam func_type FUNC_LIVE  = 3'd0;
   localparam func_type FUNC_MOVE  = 3'd1;
   localparam func_type FUNC_SUB   = 3'd2;
   localparam func_type FUNC_MCP   = 3'd3;
   localparam func_type FUNC_MULS  = 3'd4;
   localparam func_type FUNC_MULU  = 3'd5;
   localparam func_type FUNC_ARITH = 3'd6;
   localparam func_type FUNC_SPARE = 3'd7;

   // Operand sizes.
   typedef logic [1:0] size_type;
   localparam size_type SIZE_BYTE  = 2'd0;
   localparam size_type SIZE_WORD  = 2'd1;
   localparam size_type SIZE_DWORD = 2'd2;
   localparam size_type SIZE_OTHER = 2'd3;

   // Add rule at one sign position. The carry goes to C, or to R when
   // use_r is set.
   function automatic flags_type add_rule(input logic s, input logic d,
                                          input logic r, input logic z,
                                          input logic use_r);
      flags_type f;
      flags_type cbit;
      f    = '0;
      cbit = use_r ? FL_R : FL_C;
      if (r) begin
         f = f | FL_N;
         if (!s && !d) begin
            f = f | FL_V;
         end else if (s && d) begin
            f = f | cbit;
         end
      end else begin
         if (z) begin
            f = f | FL_Z;
         end
         if (s && d) begin
            f = f | FL_V;
         end
         if (s || d) begin
            f = f | cbit;
         end
      end
      return f;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/lazy_condition_flag_evaluator_top.sv */
// ---------------------------------------------------------------------------
// lazy_condition_flag_evaluator_top
// Evaluates one deferred flag job per item and returns the new
// condition-code status word.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one flag job per item: class, size, operands,
//   result, product high word, old status word, update mask and the
//   extended bit. The rsp_ channel returns the updated status word.
//   Both channels use valid and stall; an item moves at a clock edge where
//   valid is high and stall is low.
//   rsp_valid rises once an accepted item has passed through the stage one,
//   stage two and stage three registers. With no stall, one item is accepted
//   per cycle, so throughput is one item per clock.
//   Stage one reduces the operands to sign and zero bits, stage two picks
//   the flags for the class, stage three merges them into the old word.
//   Each stage holds while the stage after it is full and stalled; an empty
//   stage always takes data, so a stalled output still lets earlier items
//   move up into empty stages. req_stall rises only when all stages are
//   full and rsp_stall is high.
//   Synchronous reset empties the pipeline; no result is pending after it.
// ---------------------------------------------------------------------------
`default_nettype none

module lazy_condition_flag_evaluator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [1:0]  req_size_code,
   input  wire logic [31:0] req_src_value,
   input  wire logic [31:0] req_dst_value,
   input  wire logic [31:0] req_result_value,
   input  wire logic [31:0] req_mof_value,
   input  wire logic [31:0] req_ccs_in,
   input  wire logic [31:0] req_flag_mask,
   input  wire logic        req_extended,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_ccs_out
);

   // Stage advance enables: a stage loads when empty or when its content
   // moves on.
   logic adv1, adv2, adv3;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   assign adv3      = !v3_ff || !rsp_stall;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;

   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage one: sign and zero bits of the operands.
   lcfe_pkg::func_type func1_ff, func1_in;
   lcfe_pkg::size_type size1_ff, size1_in;
   logic [2:0]  s1_ff, s1_in;   // source signs at bits 7, 15, 31
   logic [2:0]  d1_ff, d1_in;   // destination signs
   logic [2:0]  r1_ff, r1_in;   // result signs
   logic [2:0]  rz1_ff, rz1_in; // result zero over byte, word, dword
   logic        mz1_ff, mz1_in, mo1_ff, mo1_in, m31_1_ff, m31_1_in;
   logic [31:0] ccs1_ff, ccs1_in, mask1_ff, mask1_in;
   logic        ext1_ff, ext1_in;
   logic [31:0] src_eff;

   // Subtract and compare work on the inverted source.
   assign src_eff  = (req_func == lcfe_pkg::FUNC_SUB) ? ~req_src_value : req_src_value;
   assign func1_in = req_func;
   assign size1_in = req_size_code;
   assign s1_in    = {src_eff[31], src_eff[15], src_eff[7]};
   assign d1_in    = {req_dst_value[31], req_dst_value[15], req_dst_value[7]};
   assign r1_in    = {req_result_value[31], req_result_value[15], req_result_value[7]};
   assign rz1_in   = {req_result_value == 32'd0, req_result_value[15:0] == 16'd0,
                      req_result_value[7:0] == 8'd0};
   assign mz1_in   = req_mof_value == 32'd0;
   assign mo1_in   = &req_mof_value;
   assign m31_1_in = req_mof_value[31];
   assign ccs1_in  = req_ccs_in;
   assign mask1_in = req_flag_mask;
   assign ext1_in  = req_extended;

   always_ff @(posedge clock) begin
      if (adv1) begin
         func1_ff <= func1_in;
         size1_ff <= size1_in;
         s1_ff    <= s1_in;
         d1_ff    <= d1_in;
         r1_ff    <= r1_in;
         rz1_ff   <= rz1_in;
         mz1_ff   <= mz1_in;
         mo1_ff   <= mo1_in;
         m31_1_ff <= m31_1_in;
         ccs1_ff  <= ccs1_in;
         mask1_ff <= mask1_in;
         ext1_ff  <= ext1_in;
      end
   end

   // Stage two: flag selection by operation class.
   lcfe_pkg::flags_type generic_flags, flags2_in, flags2_ff;
   logic        live2_ff, live2_in;
   logic [31:0] ccs2_ff, mask2_ff;
   logic        ext2_ff;
   logic        mul_z;

   always_comb begin
      unique case (size1_ff)
         lcfe_pkg::SIZE_BYTE:
            generic_flags = lcfe_pkg::add_rule(s1_ff[0], d1_ff[0], r1_ff[0], rz1_ff[0], 1'b0);
         lcfe_pkg::SIZE_WORD:
            generic_flags = lcfe_pkg::add_rule(s1_ff[1], d1_ff[1], r1_ff[1], rz1_ff[1], 1'b0);
         lcfe_pkg::SIZE_DWORD:
            generic_flags = lcfe_pkg::add_rule(s1_ff[2], d1_ff[2], r1_ff[2], rz1_ff[2], 1'b0);
         default:
            generic_flags = '0;
      endcase
   end

   assign mul_z    = mz1_ff && rz1_ff[2];
   assign live2_in = func1_ff == lcfe_pkg::FUNC_LIVE;

   always_comb begin
      flags2_in = '0;
      unique case (func1_ff)
         lcfe_pkg::FUNC_LIVE: begin
            flags2_in = '0;
         end
         lcfe_pkg::FUNC_MOVE: begin
            if (size1_ff == lcfe_pkg::SIZE_DWORD) begin
               flags2_in = r1_ff[2] ? lcfe_pkg::FL_N
                         : (rz1_ff[2] ? lcfe_pkg::FL_Z : '0);
            end else if (size1_ff == lcfe_pkg::SIZE_WORD) begin
               flags2_in = r1_ff[1] ? lcfe_pkg::FL_N
                         : (rz1_ff[2] ? lcfe_pkg::FL_Z : '0);
            end else begin
               flags2_in = generic_flags;
            end
         end
         lcfe_pkg::FUNC_SUB: begin
            flags2_in = generic_flags ^ lcfe_pkg::FL_C;
         end
         lcfe_pkg::FUNC_MCP: begin
            flags2_in = lcfe_pkg::add_rule(s1_ff[2], d1_ff[2], r1_ff[2], rz1_ff[2], 1'b1);
         end
         lcfe_pkg::FUNC_MULS, lcfe_pkg::FUNC_MULU: begin
            if (mul_z) begin
               flags2_in = flags2_in | lcfe_pkg::FL_Z;
            end else if (m31_1_ff) begin
               flags2_in = flags2_in | lcfe_pkg::FL_N;
            end
            // Overflow when the high word is not the sign extension (signed) or not zero (unsigned).
            if (func1_ff == lcfe_pkg::FUNC_MULS) begin
               if (r1_ff[2] ? !mo1_ff : !mz1_ff) begin
                  flags2_in = flags2_in | lcfe_pkg::FL_V;
               end
            end else if (!mz1_ff) begin
               flags2_in = flags2_in | lcfe_pkg::FL_V;
            end
         end
         lcfe_pkg::FUNC_ARITH, lcfe_pkg::FUNC_SPARE: begin
            flags2_in = generic_flags;
         end
         default: begin
            flags2_in = generic_flags;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         flags2_ff <= flags2_in;
         live2_ff  <= live2_in;
         ccs2_ff   <= ccs1_ff;
         mask2_ff  <= mask1_ff;
         ext2_ff   <= ext1_ff;
      end
   end

   // Stage three: merge the flags into the old word under the mask; live jobs keep the old word.
   logic [31:0] wb_mask, wb_flags, ccs3_in, ccs3_ff;

   always_comb begin
      wb_mask = mask2_ff | {23'd0, lcfe_pkg::FL_X};
      if (ext2_ff) begin
         wb_mask = wb_mask & ~{23'd0, flags2_ff & lcfe_pkg::FL_Z};
      end
      wb_flags = {23'd0, flags2_ff} & wb_mask;
      ccs3_in  = live2_ff ? ccs2_ff : ((ccs2_ff & ~wb_mask) | wb_flags);
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         ccs3_ff <= ccs3_in;
      end
   end

   assign rsp_valid   = v3_ff;
   assign rsp_ccs_out = ccs3_ff;

endmodule

`default_nettype wire
